### design/bisu_pkg.sv
`default_nettype none

package bisu_pkg;

  localparam int MAX_ELEMENTS = 256;
  localparam int MAX_SEGMENTS = 16;

  localparam int FIFO_DEPTH = 4;

  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 8;
  localparam int VALUE_W = 32;
  localparam int SCNT_W  = 5;
  localparam int SLEN_W  = 9;
  localparam int POS_W   = 9;
  localparam int CMP_W   = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [SLEN_W-1:0] SEG_LEN_MAX = 9'd256;

  localparam logic [KIND_W-1:0] KIND_LOAD_ELEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_BOUND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_LEN   = 1'b1;

  typedef enum logic [1:0] {
    OP_LOAD_ELEM,
    OP_LOAD_BOUND,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [SCNT_W-1:0] seg_count;
    logic [SLEN_W-1:0] seg_len;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INDEX,
    ST_BASE,
    ST_ISSUE,
    ST_SCAN
  } st_t;

endpackage

`default_nettype wire

### design/bisu_ram.sv
`default_nettype none

module bisu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/bisu_fifo.sv
`default_nettype none

module bisu_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bisu_pkg::item_t push_item,
  input  wire logic           pop,
  output bisu_pkg::item_t     head,
  output logic                empty,
  output logic                full
);

  localparam int DEPTH = bisu_pkg::FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  bisu_pkg::item_t entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (PW+1)'(DEPTH));
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH-1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH-1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

### design/bisu_front.sv
`default_nettype none

module bisu_front #(
  parameter int MAX_ELEMENTS = bisu_pkg::MAX_ELEMENTS,
  parameter int MAX_SEGMENTS = bisu_pkg::MAX_SEGMENTS
) (
  input  wire logic                          start,
  input  wire logic [bisu_pkg::KIND_W-1:0]   kind,
  input  wire logic [bisu_pkg::SLOT_W-1:0]   slot,
  input  wire logic [bisu_pkg::VALUE_W-1:0]  value,
  input  wire logic                          queue_full,
  output logic                               busy,
  output logic                               push,
  output bisu_pkg::item_t                    item
);

  logic keep;

  // Loads outside the store and unknown kinds are accepted but dropped here.
  always_comb begin
    item.slot  = slot;
    item.value = value;
    unique case (kind)
      bisu_pkg::KIND_LOAD_ELEM: begin
        item.op = bisu_pkg::OP_LOAD_ELEM;
        keep    = ({5'b0, slot} < 13'(MAX_ELEMENTS));
      end
      bisu_pkg::KIND_LOAD_BOUND: begin
        item.op = bisu_pkg::OP_LOAD_BOUND;
        keep    = ({1'b0, slot} < 9'(MAX_SEGMENTS));
      end
      bisu_pkg::KIND_QUERY: begin
        item.op = bisu_pkg::OP_QUERY;
        keep    = 1'b1;
      end
      default: begin
        item.op = bisu_pkg::OP_QUERY;
        keep    = 1'b0;
      end
    endcase
  end

  assign busy = queue_full;
  assign push = start && !queue_full && keep;

endmodule

`default_nettype wire

### design/bisu_back.sv
`default_nettype none

module bisu_back #(
  parameter int MAX_ELEMENTS = bisu_pkg::MAX_ELEMENTS,
  parameter int MAX_SEGMENTS = bisu_pkg::MAX_SEGMENTS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bisu_pkg::cfg_t              cfg,
  input  wire bisu_pkg::item_t             head,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             res_valid,
  output logic                             res_found,
  output logic [bisu_pkg::POS_W-1:0]       res_position,
  output logic [bisu_pkg::CMP_W-1:0]       res_compares
);

  localparam int EA = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int SW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int BW = ((SW + bisu_pkg::SLEN_W) > (EA + 1)) ?
                      (SW + bisu_pkg::SLEN_W) : (EA + 1);

  bisu_pkg::st_t state_r, state_nxt;

  logic [31:0]                    key_r, key_nxt;
  logic [31:0]                    prev_r, prev_nxt;
  logic [SW-1:0]                  idx_r, idx_nxt;
  logic [SW-1:0]                  seg_r, seg_nxt;
  logic [BW-1:0]                  base_r, base_nxt;
  logic [EA-1:0]                  addr_r, addr_nxt;
  logic [bisu_pkg::SLEN_W-1:0]    j_r, j_nxt;
  logic [bisu_pkg::CMP_W-1:0]     cmp_r, cmp_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_found_r, out_found_nxt;
  logic [bisu_pkg::POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [bisu_pkg::CMP_W-1:0]     out_cmp_r, out_cmp_nxt;

  logic          e_we, b_we;
  logic [EA-1:0] e_raddr;
  logic [SW-1:0] b_raddr;
  logic [31:0]   e_rdata, b_rdata;
  logic          b_hit, idx_last;
  logic [EA:0]   pos_full;

  bisu_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (EA'(head.slot)),
    .wdata (head.value),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  bisu_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_bound_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (SW'(head.slot)),
    .wdata (head.value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Bounds are signed; segment 0 takes everything up to its bound, later
  // segments need the key above the previous bound as well.
  assign b_hit = (idx_r == '0) ? ($signed(key_r) <= $signed(b_rdata)) :
                 (($signed(prev_r) < $signed(key_r)) &&
                  ($signed(key_r) <= $signed(b_rdata)));
  assign idx_last = ((bisu_pkg::SCNT_W'(idx_r) + bisu_pkg::SCNT_W'(1)) == cfg.seg_count);
  assign pos_full = {1'b0, addr_r} + (EA+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    key_nxt       = key_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    seg_nxt       = seg_r;
    base_nxt      = base_r;
    addr_nxt      = addr_r;
    j_nxt         = j_r;
    cmp_nxt       = cmp_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    out_pos_nxt   = out_pos_r;
    out_cmp_nxt   = out_cmp_r;
    pop           = 1'b0;
    e_we          = 1'b0;
    b_we          = 1'b0;
    b_raddr       = idx_r;
    e_raddr       = addr_r;

    unique case (state_r)
      bisu_pkg::ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (head.op)
            bisu_pkg::OP_LOAD_ELEM:  e_we = 1'b1;
            bisu_pkg::OP_LOAD_BOUND: b_we = 1'b1;
            bisu_pkg::OP_QUERY: begin
              key_nxt   = head.value;
              idx_nxt   = '0;
              cmp_nxt   = '0;
              b_raddr   = '0;
              state_nxt = bisu_pkg::ST_INDEX;
            end
            default: ;
          endcase
        end
      end

      bisu_pkg::ST_INDEX: begin
        cmp_nxt = cmp_r + bisu_pkg::CMP_W'(1);
        if (b_hit) begin
          seg_nxt   = idx_r;
          state_nxt = bisu_pkg::ST_BASE;
        end else if (idx_last) begin
          seg_nxt   = '0;
          state_nxt = bisu_pkg::ST_BASE;
        end else begin
          prev_nxt = b_rdata;
          idx_nxt  = idx_r + SW'(1);
          b_raddr  = idx_r + SW'(1);
        end
      end

      bisu_pkg::ST_BASE: begin
        base_nxt  = BW'(seg_r) * BW'(cfg.seg_len);
        state_nxt = bisu_pkg::ST_ISSUE;
      end

      bisu_pkg::ST_ISSUE: begin
        if (base_r >= BW'(MAX_ELEMENTS)) begin
          // The chosen segment starts past the end of the store.
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          out_cmp_nxt   = cmp_r;
          state_nxt     = bisu_pkg::ST_IDLE;
        end else begin
          addr_nxt  = EA'(base_r);
          e_raddr   = EA'(base_r);
          j_nxt     = '0;
          state_nxt = bisu_pkg::ST_SCAN;
        end
      end

      bisu_pkg::ST_SCAN: begin
        cmp_nxt = cmp_r + bisu_pkg::CMP_W'(1);
        if (e_rdata == key_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          out_pos_nxt   = bisu_pkg::POS_W'(pos_full);
          out_cmp_nxt   = cmp_r + bisu_pkg::CMP_W'(1);
          state_nxt     = bisu_pkg::ST_IDLE;
        end else if (((j_r + bisu_pkg::SLEN_W'(1)) == cfg.seg_len) ||
                     (addr_r == EA'(MAX_ELEMENTS-1))) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b0;
          out_pos_nxt   = '0;
          out_cmp_nxt   = cmp_r + bisu_pkg::CMP_W'(1);
          state_nxt     = bisu_pkg::ST_IDLE;
        end else begin
          addr_nxt = addr_r + EA'(1);
          e_raddr  = addr_r + EA'(1);
          j_nxt    = j_r + bisu_pkg::SLEN_W'(1);
        end
      end

      default: state_nxt = bisu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bisu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r       <= key_nxt;
    prev_r      <= prev_nxt;
    idx_r       <= idx_nxt;
    seg_r       <= seg_nxt;
    base_r      <= base_nxt;
    addr_r      <= addr_nxt;
    j_r         <= j_nxt;
    cmp_r       <= cmp_nxt;
    out_found_r <= out_found_nxt;
    out_pos_r   <= out_pos_nxt;
    out_cmp_r   <= out_cmp_nxt;
  end

  assign res_valid    = out_valid_r;
  assign res_found    = out_found_r;
  assign res_position = out_pos_r;
  assign res_compares = out_cmp_r;

endmodule

`default_nettype wire

### design/block_index_search_unit.sv
`default_nettype none
// A query leaves the queue, makes its k index compares in the index state, passes the base
// and issue states and makes its m element compares in the scan state, one a cycle; its
// result strobe is registered. Loads retire one per cycle while the engine is idle; a query
// holds the engine until its result, as each store has a single read port. Four
// transactions can queue. Reset clears the queue, the engine and the registers (both to 1);
// the element and bound stores keep their contents. The receiver cannot stall results.

module block_index_search_unit #(
  parameter int MAX_ELEMENTS = bisu_pkg::MAX_ELEMENTS,
  parameter int MAX_SEGMENTS = bisu_pkg::MAX_SEGMENTS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [bisu_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [bisu_pkg::SLOT_W-1:0]        in_slot,
  input  wire logic [bisu_pkg::VALUE_W-1:0]       in_value,
  output logic                                    out_valid,
  output logic                                    out_found,
  output logic [bisu_pkg::POS_W-1:0]              out_position,
  output logic [bisu_pkg::CMP_W-1:0]              out_compares,
  input  wire logic                               cfg_we,
  input  wire logic [bisu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bisu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  bisu_pkg::cfg_t  cfg_r, cfg_nxt;
  bisu_pkg::item_t push_item, head;
  logic            push, pop, q_empty, q_full;
  logic [bisu_pkg::SCNT_W-1:0] cnt_in;
  logic [bisu_pkg::SLEN_W-1:0] len_in;

  assign cnt_in = cfg_data[bisu_pkg::SCNT_W-1:0];
  assign len_in = cfg_data[bisu_pkg::SLEN_W-1:0];

  // Written values saturate into the supported range.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bisu_pkg::CFG_SEG_COUNT: begin
          if (cnt_in == '0) begin
            cfg_nxt.seg_count = bisu_pkg::SCNT_W'(1);
          end else if ({4'b0, cnt_in} > 9'(MAX_SEGMENTS)) begin
            cfg_nxt.seg_count = bisu_pkg::SCNT_W'(MAX_SEGMENTS);
          end else begin
            cfg_nxt.seg_count = cnt_in;
          end
        end
        bisu_pkg::CFG_SEG_LEN: begin
          if (len_in == '0) begin
            cfg_nxt.seg_len = bisu_pkg::SLEN_W'(1);
          end else if (len_in > bisu_pkg::SEG_LEN_MAX) begin
            cfg_nxt.seg_len = bisu_pkg::SEG_LEN_MAX;
          end else begin
            cfg_nxt.seg_len = len_in;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.seg_count <= bisu_pkg::SCNT_W'(1);
      cfg_r.seg_len   <= bisu_pkg::SLEN_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bisu_front #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_front (
    .start      (start),
    .kind       (in_kind),
    .slot       (in_slot),
    .value      (in_value),
    .queue_full (q_full),
    .busy       (busy),
    .push       (push),
    .item       (push_item)
  );

  bisu_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  bisu_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .head         (head),
    .empty        (q_empty),
    .pop          (pop),
    .res_valid    (out_valid),
    .res_found    (out_found),
    .res_position (out_position),
    .res_compares (out_compares)
  );

  // A miss never reports a position.
  a_miss_no_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("miss reported with a nonzero position");

  // Every query makes at least one index compare.
  a_cmp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_compares != '0)
    else $error("result with zero compares");

  // A query passes the index, base and issue states before its result, so results never come back to back.
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // The queue is drained only by the engine, so a full queue holds off new transactions.
  a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !push)
    else $error("transaction queued while busy");

endmodule

`default_nettype wire

### verif/testbench.sv
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bisu_pkg::*;

  localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;
  // Loads and ignored kinds still in the queue when the last result shows up.
  localparam int DRAIN_CYCLES  = 16;
  // Longest query: 16 index compares plus 256 element compares, plus overhead.
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
  } search_request_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [CMP_W-1:0] compares;
  } search_outcome_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [SLOT_W-1:0]     in_slot = '0;
  logic [VALUE_W-1:0]    in_value = '0;
  logic                  out_valid;
  logic                  out_found;
  logic [POS_W-1:0]      out_position;
  logic [CMP_W-1:0]      out_compares;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  block_index_search_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_slot      (in_slot),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_position (out_position),
    .out_compares (out_compares),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Mirror of the block: stores and geometry as the block should hold them.
  logic [VALUE_W-1:0] elem_copy  [MAX_ELEMENTS];
  logic [VALUE_W-1:0] bound_copy [MAX_SEGMENTS];
  int unsigned        seg_count_now = 1;
  int unsigned        seg_len_now = 1;

  // Store contents as planned by the stimulus generator, ahead of the block.
  logic [VALUE_W-1:0] plan_elem  [MAX_ELEMENTS];
  logic [VALUE_W-1:0] plan_bound [MAX_SEGMENTS];

  search_request_t pending_requests [$];
  search_outcome_t awaited_outcomes [$];
  int              mismatches = 0;
  int              idle_left = 0;
  int              calm_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #10ms;
    $display("testbench NOT OK");
    $finish;
  end

  function automatic search_outcome_t search_lookup(input logic [VALUE_W-1:0] key);
    search_outcome_t res;
    int unsigned     seg;
    int unsigned     tally;
    int unsigned     addr;
    seg = 0;
    tally = 0;
    res.found = 1'b0;
    res.position = '0;
    for (int i = 0; i < seg_count_now; i++) begin
      tally++;
      if (i == 0) begin
        if ($signed(key) <= $signed(bound_copy[0])) break;
      end else if ($signed(key) > $signed(bound_copy[i-1]) &&
                   $signed(key) <= $signed(bound_copy[i])) begin
        seg = i;
        break;
      end
    end
    for (int j = 0; j < seg_len_now; j++) begin
      addr = seg * seg_len_now + j;
      if (addr >= MAX_ELEMENTS) break;
      tally++;
      if (elem_copy[addr] == key) begin
        res.found = 1'b1;
        res.position = POS_W'(addr + 1);
        break;
      end
    end
    res.compares = CMP_W'(tally);
    return res;
  endfunction

  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm_left = $urandom_range(20, 60);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : request_driver
    search_request_t req;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        case (in_kind)
          KIND_LOAD_ELEM: elem_copy[in_slot] = in_value;
          KIND_LOAD_BOUND: begin
            if (in_slot < MAX_SEGMENTS) bound_copy[in_slot] = in_value;
          end
          KIND_QUERY: awaited_outcomes.push_back(search_lookup(in_value));
          default: ;
        endcase
      end
      if (!start || !busy) begin
        if (idle_left > 0) begin
          idle_left--;
          start <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          req = pending_requests.pop_front();
          start <= 1'b1;
          in_kind <= req.kind;
          in_slot <= req.slot;
          in_value <= req.value;
          idle_left = next_gap();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    search_outcome_t want;
    if (rst_n && out_valid) begin
      if (awaited_outcomes.size() == 0) begin
        $error("result transaction with no query outstanding");
        mismatches++;
      end else begin
        want = awaited_outcomes.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_found);
          mismatches++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, out_position);
          mismatches++;
        end
        if (out_compares !== want.compares) begin
          $error("compares: expected %0d, actual %0d", want.compares, out_compares);
          mismatches++;
        end
      end
    end
  end

  task automatic push_req(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                          input logic [VALUE_W-1:0] value);
    search_request_t r;
    r.kind = kind;
    r.slot = slot;
    r.value = value;
    pending_requests.push_back(r);
    if (kind == KIND_LOAD_ELEM) plan_elem[slot] = value;
    else if (kind == KIND_LOAD_BOUND && slot < MAX_SEGMENTS) plan_bound[slot] = value;
  endtask

  // Sampled between edges, once the driver has settled for the cycle.
  task automatic wait_idle();
    while (pending_requests.size() != 0 || start || awaited_outcomes.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] cnt_raw,
                              input logic [CFG_DATA_W-1:0] len_raw);
    int unsigned cnt;
    int unsigned len;
    cfg_we <= 1'b1;
    cfg_index <= CFG_SEG_COUNT;
    cfg_data <= cnt_raw;
    @(posedge clk);
    cfg_index <= CFG_SEG_LEN;
    cfg_data <= len_raw;
    @(posedge clk);
    cfg_we <= 1'b0;
    // The count register only keeps its low five bits before saturating.
    cnt = cnt_raw[SCNT_W-1:0];
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_SEGMENTS) cnt = MAX_SEGMENTS;
    len = len_raw;
    if (len < 1) len = 1;
    if (len > SEG_LEN_MAX) len = SEG_LEN_MAX;
    seg_count_now = cnt;
    seg_len_now = len;
  endtask

  function automatic bit plan_has(input logic [VALUE_W-1:0] v);
    for (int i = 0; i < MAX_ELEMENTS; i++)
      if (plan_elem[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  // Usually a value inside the bound range of the segment owning addr, else random.
  function automatic logic [VALUE_W-1:0] fitted_value(input int unsigned addr);
    int unsigned s;
    longint      lo;
    longint      hi;
    s = addr / seg_len_now;
    if (s >= seg_count_now || $urandom_range(0, 9) == 0) return $urandom;
    lo = (s == 0) ? longint'($signed(32'h8000_0000)) : longint'($signed(plan_bound[s-1])) + 1;
    hi = longint'($signed(plan_bound[s]));
    if (hi < lo) return plan_bound[s];
    return VALUE_W'(lo + longint'($urandom) % (hi - lo + 1));
  endfunction

  task automatic push_random(input bit sorted_bounds);
    int unsigned        span;
    int unsigned        pick;
    logic [VALUE_W-1:0] key;
    logic [SLOT_W-1:0]  where;
    span = seg_count_now * seg_len_now;
    if (span > MAX_ELEMENTS) span = MAX_ELEMENTS;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: key = plan_elem[$urandom_range(0, span - 1)];
        5: key = plan_bound[$urandom_range(0, seg_count_now - 1)];
        6: begin
          case ($urandom_range(0, 2))
            0: key = 32'h8000_0000;
            1: key = 32'h7FFF_FFFF;
            default: key = '0;
          endcase
        end
        default: key = $urandom;
      endcase
      push_req(KIND_QUERY, SLOT_W'($urandom), key);
    end else if (pick < 82) begin
      where = ($urandom_range(0, 4) != 0) ? SLOT_W'($urandom_range(0, span - 1))
                                          : SLOT_W'($urandom);
      push_req(KIND_LOAD_ELEM, where, fitted_value(where));
    end else if (pick < 94) begin
      // Sorted phases keep their bounds intact and only hit unused or absent entries.
      if (sorted_bounds) where = SLOT_W'($urandom_range(seg_count_now, 255));
      else if ($urandom_range(0, 1) == 0) where = SLOT_W'($urandom_range(0, MAX_SEGMENTS - 1));
      else where = SLOT_W'($urandom);
      push_req(KIND_LOAD_BOUND, where, $urandom);
    end else begin
      push_req(KIND_IGNORED, SLOT_W'($urandom), $urandom);
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] cnt_raw,
                           input logic [CFG_DATA_W-1:0] len_raw,
                           input int count, input bit sorted_bounds);
    longint      edge_val;
    longint      stride;
    int unsigned span;
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    set_geometry(cnt_raw, len_raw);
    span = seg_count_now * seg_len_now;
    if (sorted_bounds) begin
      edge_val = longint'($signed(32'h8000_0000));
      stride = 64'sd4294967296 / (seg_count_now + 1);
      for (int i = 0; i < seg_count_now; i++) begin
        if ($urandom_range(0, 15) != 0)
          edge_val = edge_val + longint'($urandom_range(0, 32'(stride)));
        push_req(KIND_LOAD_BOUND, SLOT_W'(i), VALUE_W'(edge_val));
      end
      if (span <= 64)
        for (int a = 0; a < span; a++) push_req(KIND_LOAD_ELEM, SLOT_W'(a), fitted_value(a));
    end
    repeat (count) push_random(sorted_bounds);
  endtask

  initial begin : scenario
    logic [VALUE_W-1:0] probe;
    while (!rst_n) @(posedge clk);

    // Fill both stores so that no query ever reads an entry that was never written.
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (i == 0) push_req(KIND_LOAD_ELEM, SLOT_W'(i), 32'h8000_0000);
      else if (i == MAX_ELEMENTS - 1) push_req(KIND_LOAD_ELEM, SLOT_W'(i), 32'h7FFF_FFFF);
      else push_req(KIND_LOAD_ELEM, SLOT_W'(i), $urandom);
    end
    for (int i = 0; i < MAX_SEGMENTS; i++)
      push_req(KIND_LOAD_BOUND, SLOT_W'(i), (i == 0) ? 32'h0 : $urandom);

    // Directed checks with the reset geometry of one segment of one element.
    push_req(KIND_QUERY, 8'h00, 32'h8000_0000);
    push_req(KIND_QUERY, 8'hFF, 32'h7FFF_FFFF);
    push_req(KIND_QUERY, 8'h00, 32'h0000_0000);
    // Bound slots past the index depth must not alias onto entry zero.
    push_req(KIND_LOAD_BOUND, 8'd16, 32'h7FFF_FFFF);
    push_req(KIND_LOAD_BOUND, 8'hFF, 32'h8000_0000);
    push_req(KIND_IGNORED, 8'h00, 32'h0000_0000);
    push_req(KIND_IGNORED, 8'hFF, 32'hFFFF_FFFF);
    push_req(KIND_QUERY, 8'h00, 32'h0000_0000);
    push_req(KIND_LOAD_ELEM, 8'h00, 32'h0000_0000);
    push_req(KIND_QUERY, 8'h00, 32'h0000_0000);
    push_req(KIND_LOAD_BOUND, 8'h00, 32'h7FFF_FFFF);
    push_req(KIND_QUERY, 8'h00, 32'h7FFF_FFFF);
    push_req(KIND_LOAD_ELEM, 8'h00, 32'h7FFF_FFFF);
    push_req(KIND_QUERY, 8'h00, 32'h7FFF_FFFF);
    push_req(KIND_QUERY, 8'h00, 32'hFFFF_FFFF);

    run_phase(9'd4, 9'd8, 50, 1'b1);
    run_phase(9'd16, 9'd16, 65, 1'b1);
    run_phase(9'd0, 9'd0, 35, 1'b0);

    // Largest geometry: a full miss past every bound, then a hit on the last element.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    set_geometry(9'h1FF, 9'h1FF);
    for (int i = 0; i < MAX_SEGMENTS; i++)
      push_req(KIND_LOAD_BOUND, SLOT_W'(i), VALUE_W'(-1000 + i * 10));
    probe = 32'h7FFF_FFFF;
    while (plan_has(probe)) probe--;
    push_req(KIND_QUERY, 8'h00, probe);
    probe = 32'h7FFF_FFFE;
    while (plan_has(probe)) probe--;
    push_req(KIND_LOAD_ELEM, 8'hFF, probe);
    push_req(KIND_LOAD_BOUND, 8'h00, 32'h7FFF_FFFF);
    push_req(KIND_QUERY, 8'h00, probe);
    repeat (25) push_random(1'b0);

    run_phase(9'd5, 9'd300, 20, 1'b0);
    run_phase(9'd8, 9'd32, 65, 1'b1);
    run_phase(9'd3, 9'd5, 45, 1'b0);
    run_phase(9'd16, 9'd1, 50, 1'b1);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_outcomes.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
design/bisu_pkg.sv
design/bisu_ram.sv
design/bisu_fifo.sv
design/bisu_front.sv
design/bisu_back.sv
design/block_index_search_unit.sv
verif/testbench.sv
